>>> sv/tms_pkg.sv
// Shared constants for the tabulated multiplicity sampler.
// No dependencies; imported by the top level, the checker and the testbench.
package tms_pkg;

    localparam int TABLE_DEPTH    = 64;
    localparam int ADDR_W         = $clog2(TABLE_DEPTH);
    localparam int PIU_W          = 7;
    localparam int ENERGY_BITS    = 32;
    localparam int MULT_FRAC_BITS = 16;
    localparam int MULT_BITS      = 8 + MULT_FRAC_BITS;
    localparam int RAND_BITS      = 16;
    localparam int COUNT_W        = 9;
    localparam int WHOLE_W        = MULT_BITS - MULT_FRAC_BITS;
    localparam int ALIGN_W        = (MULT_FRAC_BITS > RAND_BITS) ? MULT_FRAC_BITS : RAND_BITS;
    localparam int PROD_W         = MULT_BITS + ENERGY_BITS;
    localparam int DIV_CNT_W      = $clog2(MULT_BITS);

    // input tdata layout, lowest field first
    localparam int IN_IDX_LO   = 0;
    localparam int IN_EEN_LO   = IN_IDX_LO + ADDR_W;
    localparam int IN_EMU_LO   = IN_EEN_LO + ENERGY_BITS;
    localparam int IN_QEN_LO   = IN_EMU_LO + MULT_BITS;
    localparam int IN_RND_LO   = IN_QEN_LO + ENERGY_BITS;
    localparam int IN_USED_W   = IN_RND_LO + RAND_BITS;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_USED_W  = COUNT_W + MULT_BITS;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [PIU_W-1:0] MIN_POINTS = PIU_W'(2);
    localparam logic [PIU_W-1:0] MAX_POINTS = PIU_W'(TABLE_DEPTH);

endpackage

>>> sv/tms_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No package dependency.
module tms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/tabulated_multiplicity_sampler.sv
// Top level of the tabulated multiplicity sampler: grid tables, search
// sequencer, shared multiply/divide datapath and stochastic rounding.
// Depends on tms_pkg and tms_ram.
//
//  channel | ports                      | dir | payload
//  --------+----------------------------+-----+------------------------------------------
//  s_axis  | tvalid tready tdata tuser  | in  | tuser: action; tdata: index, energy,
//          |                            |     |   multiplicity, query energy, random
//  m_axis  | tvalid tready tdata tuser  | out | tuser: in_range; tdata: count, mult
//  cfg     | cfg_valid cfg_ready cfg_data| in | points_in_use (7 bits)
//
// A write item is stored as it is accepted, and the block stays ready for the next item.
// A sample item first checks the first and last energies and, off the grid or on the
// last point, goes straight to rounding; inside it, each search probe reads the energy
// memory via the search and probe states; a 24-step restoring divider then interpolates.
// The finished result sits in an output register; a new item is accepted while
// it waits, and a later sample only stalls in its final step until it is taken.
// Reset (synchronous, active low) clears control state and sets points_in_use
// to 2; the tables are undefined until written.
module tabulated_multiplicity_sampler (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] entry_index, [37:6] entry_energy, [61:38] entry_multiplicity,
    // [93:62] query_energy, [109:94] random_fraction, [111:110] zero
    input  logic [tms_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [0] action
    input  logic                                 s_axis_tuser,
    // result items
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [8:0] emitted_count, [32:9] interpolated_multiplicity, [39:33] zero
    output logic [tms_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // [0] in_range
    output logic                                 m_axis_tuser,
    // configuration
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tms_pkg::PIU_W-1:0]            cfg_data
);

    import tms_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_CHK0  = 4'd1;  // first energy on read port
    localparam logic [ST_W-1:0] ST_CHKN  = 4'd2;  // last energy on read port
    localparam logic [ST_W-1:0] ST_SRCH  = 4'd3;
    localparam logic [ST_W-1:0] ST_PROBE = 4'd4;
    localparam logic [ST_W-1:0] ST_LDLO  = 4'd5;
    localparam logic [ST_W-1:0] ST_LDHI  = 4'd6;
    localparam logic [ST_W-1:0] ST_MUL   = 4'd7;
    localparam logic [ST_W-1:0] ST_DIV   = 4'd8;
    localparam logic [ST_W-1:0] ST_ADJ   = 4'd9;
    localparam logic [ST_W-1:0] ST_RND   = 4'd10;

    // control
    logic [ST_W-1:0]      state_reg, state_next;
    logic [PIU_W-1:0]     points_reg;
    logic                 mvalid_reg, mvalid_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // payload
    logic [ADDR_W-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [ENERGY_BITS-1:0] qe_reg, qe_next;
    logic [RAND_BITS-1:0]   rnd_reg, rnd_next;
    logic                   lower_ok_reg, lower_ok_next;
    logic [ENERGY_BITS-1:0] e0_reg, e0_next;
    logic [MULT_BITS-1:0]   m0_reg, m0_next;
    logic [MULT_BITS-1:0]   a_reg, a_next;
    logic [ENERGY_BITS-1:0] b_reg, b_next, c_reg, c_next;
    logic                   neg_reg, neg_next;
    logic [ENERGY_BITS-1:0] rem_reg, rem_next;
    logic [MULT_BITS-1:0]   qd_reg, qd_next;
    logic [MULT_BITS-1:0]   mres_reg, mres_next;
    logic                   inr_reg, inr_next;
    logic [COUNT_W-1:0]     ocount_reg, ocount_next;
    logic [MULT_BITS-1:0]   omult_reg, omult_next;
    logic                   oinr_reg, oinr_next;

    // memories
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [ENERGY_BITS-1:0] e_rdata;
    logic [MULT_BITS-1:0]   m_rdata;

    // datapath helpers
    logic                   s_acc;
    logic [PIU_W-1:0]       n_clamped;
    logic [ADDR_W:0]        lo_hi_sum;
    logic [ADDR_W-1:0]      mid;
    logic                   gap_big;
    logic [PROD_W-1:0]      prod;
    logic [ENERGY_BITS:0]   rem_sh;
    logic                   q_bit;
    logic [WHOLE_W-1:0]     whole;
    logic [MULT_FRAC_BITS-1:0] frac;
    logic [ALIGN_W:0]       rnd_sum;
    logic                   round_up;
    logic                   out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign ram_we        = s_acc && (s_axis_tuser == ACT_WRITE);

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({omult_reg, ocount_reg});
    assign m_axis_tuser  = oinr_reg;
    assign out_free      = !mvalid_reg || m_axis_tready;

    tms_ram #(
        .WIDTH (ENERGY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_energy_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_axis_tdata[IN_IDX_LO +: ADDR_W]),
        .wdata (s_axis_tdata[IN_EEN_LO +: ENERGY_BITS]),
        .raddr (ram_raddr),
        .rdata (e_rdata)
    );

    tms_ram #(
        .WIDTH (MULT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_mult_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_axis_tdata[IN_IDX_LO +: ADDR_W]),
        .wdata (s_axis_tdata[IN_EMU_LO +: MULT_BITS]),
        .raddr (ram_raddr),
        .rdata (m_rdata)
    );

    // points in use, clamped to the table
    always_comb begin
        if (points_reg < MIN_POINTS) begin
            n_clamped = MIN_POINTS;
        end else if (points_reg > MAX_POINTS) begin
            n_clamped = MAX_POINTS;
        end else begin
            n_clamped = points_reg;
        end
    end

    assign lo_hi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = lo_hi_sum[ADDR_W:1];
    assign gap_big   = {1'b0, hi_reg} > ({1'b0, lo_reg} + (ADDR_W+1)'(1));

    // shared multiplier and one restoring divider step
    assign prod   = PROD_W'(a_reg) * PROD_W'(b_reg);
    assign rem_sh = {rem_reg, qd_reg[MULT_BITS-1]};
    assign q_bit  = rem_sh >= {1'b0, c_reg};

    // stochastic rounding: carry when random + fraction reaches one
    assign whole    = mres_reg[MULT_BITS-1:MULT_FRAC_BITS];
    assign frac     = mres_reg[MULT_FRAC_BITS-1:0];
    assign rnd_sum  = ((ALIGN_W+1)'(frac) << (ALIGN_W - MULT_FRAC_BITS))
                    + ((ALIGN_W+1)'(rnd_reg) << (ALIGN_W - RAND_BITS));
    assign round_up = (frac != '0) && rnd_sum[ALIGN_W];

    always_comb begin
        state_next    = state_reg;
        mvalid_next   = mvalid_reg;
        cnt_next      = cnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        qe_next       = qe_reg;
        rnd_next      = rnd_reg;
        lower_ok_next = lower_ok_reg;
        e0_next       = e0_reg;
        m0_next       = m0_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        neg_next      = neg_reg;
        rem_next      = rem_reg;
        qd_next       = qd_reg;
        mres_next     = mres_reg;
        inr_next      = inr_reg;
        ocount_next   = ocount_reg;
        omult_next    = omult_reg;
        oinr_next     = oinr_reg;
        ram_raddr     = lo_reg;

        if (mvalid_reg && m_axis_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                ram_raddr = '0;
                if (s_acc && (s_axis_tuser == ACT_SAMPLE)) begin
                    qe_next    = s_axis_tdata[IN_QEN_LO +: ENERGY_BITS];
                    rnd_next   = s_axis_tdata[IN_RND_LO +: RAND_BITS];
                    lo_next    = '0;
                    hi_next    = ADDR_W'(n_clamped - PIU_W'(1));
                    state_next = ST_CHK0;
                end
            end
            ST_CHK0: begin
                ram_raddr     = hi_reg;
                lower_ok_next = qe_reg >= e_rdata;
                state_next    = ST_CHKN;
            end
            ST_CHKN: begin
                if (lower_ok_reg && (qe_reg < e_rdata)) begin
                    state_next = ST_SRCH;
                end else begin
                    // exactly on the last point, or off the grid
                    if (qe_reg == e_rdata) begin
                        mres_next = m_rdata;
                        inr_next  = 1'b1;
                    end else begin
                        mres_next = '0;
                        inr_next  = 1'b0;
                    end
                    state_next = ST_RND;
                end
            end
            ST_SRCH: begin
                if (gap_big) begin
                    ram_raddr  = mid;
                    state_next = ST_PROBE;
                end else begin
                    ram_raddr  = lo_reg;
                    state_next = ST_LDLO;
                end
            end
            ST_PROBE: begin
                if (e_rdata <= qe_reg) begin
                    lo_next = mid;
                end else begin
                    hi_next = mid;
                end
                state_next = ST_SRCH;
            end
            ST_LDLO: begin
                ram_raddr  = hi_reg;
                e0_next    = e_rdata;
                m0_next    = m_rdata;
                state_next = ST_LDHI;
            end
            ST_LDHI: begin
                neg_next   = m_rdata < m0_reg;
                a_next     = (m_rdata < m0_reg) ? (m0_reg - m_rdata) : (m_rdata - m0_reg);
                b_next     = qe_reg - e0_reg;
                c_next     = e_rdata - e0_reg;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // product < a*c, so the top part is already below the divisor
                rem_next   = prod[PROD_W-1 -: ENERGY_BITS];
                qd_next    = prod[MULT_BITS-1:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = q_bit ? ENERGY_BITS'(rem_sh - {1'b0, c_reg})
                                 : rem_sh[ENERGY_BITS-1:0];
                qd_next  = {qd_reg[MULT_BITS-2:0], q_bit};
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(MULT_BITS - 1)) begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ: begin
                mres_next  = neg_reg ? (m0_reg - qd_reg) : (m0_reg + qd_reg);
                inr_next   = 1'b1;
                state_next = ST_RND;
            end
            ST_RND: begin
                if (out_free) begin
                    ocount_next = COUNT_W'(whole) + COUNT_W'(round_up);
                    omult_next  = mres_reg;
                    oinr_next   = inr_reg;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
            cnt_reg    <= '0;
            points_reg <= MIN_POINTS;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            cnt_reg    <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                points_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        qe_reg       <= qe_next;
        rnd_reg      <= rnd_next;
        lower_ok_reg <= lower_ok_next;
        e0_reg       <= e0_next;
        m0_reg       <= m0_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        qd_reg       <= qd_next;
        mres_reg     <= mres_next;
        inr_reg      <= inr_next;
        ocount_reg   <= ocount_next;
        omult_reg    <= omult_next;
        oinr_reg     <= oinr_next;
    end

endmodule

>>> tb/tms_sample_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the tabulated multiplicity sampler: mirrors the grid tables and
// points_in_use, predicts each sample result and compares it. Depends on tms_pkg.
module tms_sample_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [tms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [tms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tms_pkg::PIU_W-1:0]       cfg_data,
    output int                              fail_count,
    output int                              outstanding
);

    import tms_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic [MULT_BITS-1:0] mult;
        logic                 in_range;
    } sample_result_t;

    logic [ENERGY_BITS-1:0] energy_grid [TABLE_DEPTH];
    logic [MULT_BITS-1:0]   mult_grid   [TABLE_DEPTH];
    logic [PIU_W-1:0]       points_q;
    sample_result_t         pending_samples [$];

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_count++;
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got,
                 want);
    endtask

    function automatic sample_result_t interpolate_and_round(
        input logic [ENERGY_BITS-1:0] q_energy,
        input logic [RAND_BITS-1:0]   rnd
    );
        int unsigned          n, lo, hi, mid;
        logic [63:0]          span, offset, delta, frac_w, rnd_w;
        logic [MULT_BITS-1:0] m0, m1, mult;
        sample_result_t       res;
        n = points_q;
        if (points_q < MIN_POINTS) n = MIN_POINTS;
        if (points_q > MAX_POINTS) n = MAX_POINTS;
        mult = '0;
        res.in_range = 1'b0;
        if (q_energy >= energy_grid[0] && q_energy < energy_grid[n-1]) begin
            // invariant: grid[lo] <= q < grid[hi], so span is never zero
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (energy_grid[mid] <= q_energy) lo = mid;
                else hi = mid;
            end
            span   = 64'(energy_grid[hi]) - 64'(energy_grid[lo]);
            offset = 64'(q_energy) - 64'(energy_grid[lo]);
            m0 = mult_grid[lo];
            m1 = mult_grid[hi];
            if (m1 >= m0) begin
                delta = 64'(m1 - m0);
                mult  = m0 + MULT_BITS'((delta * offset) / span);
            end else begin
                delta = 64'(m0 - m1);
                mult  = m0 - MULT_BITS'((delta * offset) / span);
            end
            res.in_range = 1'b1;
        end else if (q_energy == energy_grid[n-1]) begin
            mult = mult_grid[n-1];
            res.in_range = 1'b1;
        end
        res.mult  = mult;
        res.count = COUNT_W'(mult >> MULT_FRAC_BITS);
        // stochastic rounding: round up when random + fraction reaches one
        frac_w = 64'(mult[MULT_FRAC_BITS-1:0]);
        rnd_w  = 64'(rnd);
        if (frac_w != 0 && (frac_w << RAND_BITS) + (rnd_w << MULT_FRAC_BITS) >=
                           (64'd1 << (MULT_FRAC_BITS + RAND_BITS)))
            res.count = res.count + 1'b1;
        return res;
    endfunction

    always @(posedge aclk) begin
        sample_result_t got, want;
        if (!aresetn) begin
            points_q = MIN_POINTS;
            pending_samples.delete();
        end else begin
            // results first, so a result can never match an item accepted this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got.count    = m_axis_tdata[0 +: COUNT_W];
                got.mult     = m_axis_tdata[COUNT_W +: MULT_BITS];
                got.in_range = m_axis_tuser;
                if (pending_samples.size() == 0) begin
                    flag_mismatch("unexpected result, count", 32'(got.count), 32'd0);
                end else begin
                    want = pending_samples.pop_front();
                    if (got.count != want.count)
                        flag_mismatch("emitted_count", 32'(got.count), 32'(want.count));
                    if (got.mult != want.mult)
                        flag_mismatch("interpolated_multiplicity", 32'(got.mult),
                                      32'(want.mult));
                    if (got.in_range != want.in_range)
                        flag_mismatch("in_range", 32'(got.in_range), 32'(want.in_range));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ACT_WRITE) begin
                    energy_grid[s_axis_tdata[IN_IDX_LO +: ADDR_W]] =
                        s_axis_tdata[IN_EEN_LO +: ENERGY_BITS];
                    mult_grid[s_axis_tdata[IN_IDX_LO +: ADDR_W]] =
                        s_axis_tdata[IN_EMU_LO +: MULT_BITS];
                end else begin
                    pending_samples.push_back(interpolate_and_round(
                        s_axis_tdata[IN_QEN_LO +: ENERGY_BITS],
                        s_axis_tdata[IN_RND_LO +: RAND_BITS]));
                end
            end
            if (cfg_valid && cfg_ready)
                points_q = cfg_data;
        end
        outstanding = pending_samples.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the sampler testbench: clock, reset, item and config stimulus, result
// back-pressure and verdict. Depends on tms_pkg, tms_sample_checker and the RTL.
module tb;
    import tms_pkg::*;

    // wait well past the longest sample before config writes
    localparam int DRAIN_CYCLES   = 80;
    localparam int ITEM_TARGET    = 1250;
    // long receiver hold-off, so the block fills and drops s_axis_tready
    localparam int LONG_HOLD      = 400;
    localparam int PRESSURE_PHASE = 6;
    // slowest correct run: ~1250 items, each with the longest sample, send gap and result
    // stall, plus phase drains and the long hold; several times that
    localparam int CYCLE_LIMIT    = 600000;

    typedef enum {SHAPE_SPREAD, SHAPE_PLATEAU, SHAPE_SHUFFLED, SHAPE_DENSE} table_shape_t;
    typedef enum {Q_BETWEEN, Q_POINT, Q_LAST, Q_BELOW, Q_ABOVE, Q_ANY, Q_EDGE} query_kind_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // index, energy, mult, query energy, random
    logic                   s_axis_tuser;   // action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // emitted_count, interpolated_multiplicity
    logic                   m_axis_tuser;   // in_range
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [PIU_W-1:0]       cfg_data;

    int          fail_count;
    int          outstanding;
    int unsigned cycles;
    int unsigned items_sent;

    // stimulus-side copy of the table, only used to aim queries at the grid
    logic [ENERGY_BITS-1:0] stim_energy [TABLE_DEPTH];

    // sender pacing: calm stretches with no gaps, rush forces back-to-back items
    bit          tx_calm, tx_rush;
    int unsigned tx_left;
    // receiver pacing and the one-shot long hold
    bit          hold_req, hold_done;

    always #6 aclk = ~aclk;

    tabulated_multiplicity_sampler u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    tms_sample_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    // valid stays high into the next item when it has no gap.
    task automatic send_item(
        input logic                   act,
        input logic [ADDR_W-1:0]      idx,
        input logic [ENERGY_BITS-1:0] e_energy,
        input logic [MULT_BITS-1:0]   e_mult,
        input logic [ENERGY_BITS-1:0] q_energy,
        input logic [RAND_BITS-1:0]   rnd
    );
        int unsigned           gap;
        logic [IN_TDATA_W-1:0] payload;
        gap = (tx_calm || tx_rush) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        payload = '0;
        payload[IN_IDX_LO +: ADDR_W]      = idx;
        payload[IN_EEN_LO +: ENERGY_BITS] = e_energy;
        payload[IN_EMU_LO +: MULT_BITS]   = e_mult;
        payload[IN_QEN_LO +: ENERGY_BITS] = q_energy;
        payload[IN_RND_LO +: RAND_BITS]   = rnd;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        if (act == ACT_WRITE)
            stim_energy[idx] = e_energy;
        items_sent++;
        if (tx_left == 0) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            tx_left = $urandom_range(8, 48);
        end
        tx_left--;
        @(negedge aclk);
    endtask

    // drop valid, wait for every expected result, then let the datapath settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_points_in_use(input logic [PIU_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stall per item, calm stretches, one long hold-off
    initial begin
        int unsigned gap, rx_left;
        bit          rx_calm;
        m_axis_tready = 1'b0;
        rx_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (rx_left == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
                rx_left = $urandom_range(8, 48);
            end
            rx_left--;
            gap = rx_calm ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        int                     phase, i, k, pick, n_eff, n_samples;
        logic [PIU_W-1:0]       setting;
        logic [ENERGY_BITS-1:0] e, prev, room, stride_cap, stride, q;
        logic [MULT_BITS-1:0]   mu;
        logic [RAND_BITS-1:0]   rnd;
        table_shape_t           shape;
        query_kind_t            qk;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_WRITE;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        aresetn       = 1'b0;
        tx_calm       = 1'b0;
        tx_rush       = 1'b0;
        tx_left       = 0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        items_sent    = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset value of points_in_use (2): grid spans the full energy
        // range and the multiplicity range, plus the top slot index.
        send_item(ACT_WRITE, ADDR_W'(0), '0, '0, $urandom(), RAND_BITS'($urandom()));
        send_item(ACT_WRITE, ADDR_W'(1), '1, '1, $urandom(), RAND_BITS'($urandom()));
        send_item(ACT_WRITE, '1, $urandom(), MULT_BITS'($urandom()), $urandom(),
                  RAND_BITS'($urandom()));
        // first point exactly, integer value: no round-up even with max random
        send_item(ACT_SAMPLE, '0, '0, '0, 0, '1);
        // last point, max multiplicity rounds up to the largest count
        send_item(ACT_SAMPLE, '0, '0, '0, '1, '1);
        send_item(ACT_SAMPLE, '0, '0, '0, '1, '0);
        send_item(ACT_SAMPLE, '0, '0, '0, 32'h8000_0000, 16'h8000);
        send_item(ACT_SAMPLE, '0, '0, '0, 32'hFFFF_FFFE, 16'h0001);

        // Directed, 4 points: falling segment, flat top with repeated energy,
        // queries below, above, at the last point, between points and on the first point.
        wait_idle();
        set_points_in_use(PIU_W'(4));
        send_item(ACT_WRITE, ADDR_W'(0), 100, 24'h05_0000, $urandom(),
                  RAND_BITS'($urandom()));
        send_item(ACT_WRITE, ADDR_W'(1), 200, 24'h01_8000, $urandom(),
                  RAND_BITS'($urandom()));
        send_item(ACT_WRITE, ADDR_W'(2), 300, 24'h02_0000, $urandom(),
                  RAND_BITS'($urandom()));
        send_item(ACT_WRITE, ADDR_W'(3), 300, 24'h0A_0000, $urandom(),
                  RAND_BITS'($urandom()));
        send_item(ACT_SAMPLE, '0, '0, '0, 99, '1);
        send_item(ACT_SAMPLE, '0, '0, '0, 301, '1);
        send_item(ACT_SAMPLE, '0, '0, '0, 300, '1);
        send_item(ACT_SAMPLE, '0, '0, '0, 150, '0);
        send_item(ACT_SAMPLE, '0, '0, '0, 250, 16'h8000);
        send_item(ACT_SAMPLE, '0, '0, '0, 100, '0);

        // Random phases: new setting, fresh table for the points in use, then
        // mostly samples aimed at the grid with a few stray writes mixed in.
        for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
            case (phase)
                0: setting = MAX_POINTS;
                1: setting = '0;
                2: setting = '1;
                3: setting = PIU_W'(1);
                4: setting = MAX_POINTS + 1'b1;
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        setting = PIU_W'($urandom());
                    else if (pick == 1)
                        setting = PIU_W'($urandom_range(MIN_POINTS, MAX_POINTS));
                    else
                        setting = PIU_W'($urandom_range(MIN_POINTS, 10));
                end
            endcase
            n_eff = setting;
            if (setting < MIN_POINTS) n_eff = MIN_POINTS;
            if (setting > MAX_POINTS) n_eff = MAX_POINTS;
            wait_idle();
            set_points_in_use(setting);

            shape = table_shape_t'($urandom_range(0, SHAPE_DENSE));
            prev  = '0;
            for (i = 0; i < n_eff; i++) begin
                case (shape)
                    SHAPE_SHUFFLED: e = $urandom();
                    SHAPE_DENSE: e = (i == 0) ? ($urandom() >> 4) : prev + $urandom_range(1, 3);
                    default: begin
                        if (i == 0) begin
                            e = $urandom() >> $urandom_range(1, 31);
                        end else begin
                            // leave room for the remaining points
                            room       = '1 - prev;
                            stride_cap = room / (n_eff - i);
                            if (shape == SHAPE_PLATEAU && $urandom_range(0, 2) == 0)
                                stride = '0;
                            else if (stride_cap == 0)
                                stride = '0;
                            else
                                stride = $urandom_range(1, stride_cap >> $urandom_range(0, 12));
                            e = prev + stride;
                        end
                    end
                endcase
                prev = e;
                pick = $urandom_range(0, 7);
                mu = (pick == 0) ? '0 : (pick == 1) ? '1 : MULT_BITS'($urandom());
                send_item(ACT_WRITE, ADDR_W'(i), e, mu, $urandom(), RAND_BITS'($urandom()));
            end

            n_samples = $urandom_range(10, 50);
            if (phase == PRESSURE_PHASE) begin
                n_samples = 40;
                tx_rush   = 1'b1;
                hold_req  = 1'b1;
            end
            for (k = 0; k < n_samples; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    // stray write, may break the ordering of the table in use
                    send_item(ACT_WRITE, ADDR_W'($urandom()), $urandom(),
                              MULT_BITS'($urandom()), $urandom(), RAND_BITS'($urandom()));
                end else begin
                    pick = $urandom_range(0, 11);
                    qk   = (pick > Q_EDGE) ? Q_BETWEEN : query_kind_t'(pick);
                    i    = $urandom_range(0, n_eff - 2);
                    case (qk)
                        Q_BETWEEN: q = (stim_energy[i+1] > stim_energy[i]) ?
                            stim_energy[i] + $urandom_range(0, stim_energy[i+1] -
                                                               stim_energy[i] - 1) :
                            stim_energy[i];
                        Q_POINT: q = stim_energy[$urandom_range(0, n_eff - 1)];
                        Q_LAST:  q = stim_energy[n_eff-1];
                        Q_BELOW: q = (stim_energy[0] == 0) ? '0 :
                                     $urandom_range(0, stim_energy[0] - 1);
                        Q_ABOVE: q = (stim_energy[n_eff-1] == '1) ? '1 :
                                     $urandom_range(stim_energy[n_eff-1] + 1, '1);
                        Q_ANY:   q = $urandom();
                        default: q = $urandom_range(0, 1) ? {ENERGY_BITS{1'b1}} : '0;
                    endcase
                    pick = $urandom_range(0, 9);
                    rnd  = (pick == 0) ? '0 : (pick == 1) ? '1 : RAND_BITS'($urandom());
                    send_item(ACT_SAMPLE, ADDR_W'($urandom()), $urandom(),
                              MULT_BITS'($urandom()), q, rnd);
                end
            end
            tx_rush = 1'b0;
        end

        wait_idle();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
sv/tms_pkg.sv
sv/tms_ram.sv
sv/tabulated_multiplicity_sampler.sv
tb/tms_sample_checker.sv
tb/tb.sv
